// ----- sv/pbm_pkg.sv -----
`default_nettype none

package pbm_pkg;

  // Number of color bytes in one pixel.
  localparam int unsigned NumBytes = 3;

  typedef logic [7:0] pbm_byte_t;
  typedef logic [2:0] pbm_mode_t;
  typedef logic [3:0] pbm_reg_idx_t;

  // Blend mode codes held in the mode register.
  localparam pbm_mode_t MODE_COPY   = 3'd0;
  localparam pbm_mode_t MODE_KEY    = 3'd1;
  localparam pbm_mode_t MODE_AVG    = 3'd2;
  localparam pbm_mode_t MODE_W80    = 3'd3;
  localparam pbm_mode_t MODE_DARKER = 3'd4;

  // Configuration register indexes.
  localparam pbm_reg_idx_t REG_MODE = 4'd0;
  localparam pbm_reg_idx_t REG_KEY0 = 4'd1;
  localparam pbm_reg_idx_t REG_KEY1 = 4'd2;
  localparam pbm_reg_idx_t REG_KEY2 = 4'd3;

  // Green byte value that always counts as a match in color-key mode.
  localparam pbm_byte_t KEY_GREEN_ALIAS = 8'd3;
  localparam pbm_byte_t BYTE_MAX        = 8'd255;

  // Reciprocal multipliers. floor(x * RECIP5 / 2^16) equals floor(x / 5)
  // and floor(x * RECIP10 / 2^16) equals floor(x / 10) for all x below
  // 16384, which covers the 11-bit and 12-bit weighted sums used here.
  localparam logic [13:0] RECIP5  = 14'd13108;
  localparam logic [12:0] RECIP10 = 13'd6554;

  typedef struct packed {
    pbm_byte_t key0;
    pbm_byte_t key1;
    pbm_byte_t key2;
    pbm_mode_t mode;
  } pbm_cfg_t;

  // After the front stage: weighted sums, average and per-pixel flags.
  typedef struct packed {
    pbm_mode_t                 mode;
    pbm_byte_t [NumBytes-1:0]  src;
    pbm_byte_t [NumBytes-1:0]  dst;
    pbm_byte_t [NumBytes-1:0]  avg;
    logic [NumBytes-1:0][10:0] sum5;
    logic [NumBytes-1:0][11:0] sum10;
    logic [NumBytes-1:0]       darker;
    logic                      key_hit;
    logic                      dark_key_hit;
    logic                      avg_ok;
  } pbm_s1_t;

  // After the scaling stage: quotients replace the wide sums.
  typedef struct packed {
    pbm_mode_t                mode;
    pbm_byte_t [NumBytes-1:0] src;
    pbm_byte_t [NumBytes-1:0] dst;
    pbm_byte_t [NumBytes-1:0] avg;
    pbm_byte_t [NumBytes-1:0] q5;
    pbm_byte_t [NumBytes-1:0] q10;
    logic [NumBytes-1:0]      darker;
    logic                     key_hit;
    logic                     dark_key_hit;
    logic                     avg_ok;
  } pbm_s2_t;

endpackage

`default_nettype wire

// ----- sv/pbm_front.sv -----
`default_nettype none

module pbm_front
  import pbm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire pbm_cfg_t                 cfg,
  input  wire pbm_byte_t [NumBytes-1:0] src,
  input  wire pbm_byte_t [NumBytes-1:0] dst,
  output logic                          out_valid,
  output pbm_s1_t                       out_data
);

  pbm_s1_t data_next;
  logic    eq0;
  logic    eq1;
  logic    eq2;
  logic [8:0] pair_sum;

  always_comb begin
    data_next      = '0;
    pair_sum       = '0;
    data_next.mode = cfg.mode;
    data_next.src  = src;
    data_next.dst  = dst;
    for (int i = 0; i < NumBytes; i++) begin
      pair_sum              = {1'b0, dst[i]} + {1'b0, src[i]};
      data_next.avg[i]      = pair_sum[8:1];
      // dst*20 + src*80 over 100 reduces to (dst + 4*src) / 5.
      data_next.sum5[i]     = {3'b000, dst[i]} + {1'b0, src[i], 2'b00};
      data_next.sum10[i]    = {3'b000, dst[i], 1'b0} + {4'b0000, dst[i]}
                            + {1'b0, src[i], 3'b000} - {4'b0000, src[i]};
      data_next.darker[i]   = src[i] < dst[i];
    end
    eq0 = src[0] == cfg.key0;
    eq1 = src[1] == cfg.key1;
    eq2 = src[2] == cfg.key2;
    data_next.key_hit      = eq0 && (eq1 || src[1] == KEY_GREEN_ALIAS) && eq2;
    data_next.dark_key_hit = eq0 && eq1 && eq2;
    data_next.avg_ok       = src[0] != BYTE_MAX && src[1] != BYTE_MAX
                           && src[2] != BYTE_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pbm_scale.sv -----
`default_nettype none

module pbm_scale
  import pbm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire pbm_s1_t in_data,
  output logic         out_valid,
  output pbm_s2_t      out_data
);

  pbm_s2_t     data_next;
  logic [24:0] prod5;
  logic [24:0] prod10;

  always_comb begin
    data_next              = '0;
    prod5                  = '0;
    prod10                 = '0;
    data_next.mode         = in_data.mode;
    data_next.src          = in_data.src;
    data_next.dst          = in_data.dst;
    data_next.avg          = in_data.avg;
    data_next.darker       = in_data.darker;
    data_next.key_hit      = in_data.key_hit;
    data_next.dark_key_hit = in_data.dark_key_hit;
    data_next.avg_ok       = in_data.avg_ok;
    for (int i = 0; i < NumBytes; i++) begin
      prod5            = 25'(in_data.sum5[i]) * 25'(RECIP5);
      prod10           = 25'(in_data.sum10[i]) * 25'(RECIP10);
      data_next.q5[i]  = prod5[23:16];
      data_next.q10[i] = prod10[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pbm_select.sv -----
`default_nettype none

module pbm_select
  import pbm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire pbm_s2_t              in_data,
  output logic                      out_valid,
  output pbm_byte_t [NumBytes-1:0]  out_pixel
);

  pbm_byte_t [NumBytes-1:0] pixel_next;

  always_comb begin
    pixel_next = in_data.dst;
    case (in_data.mode)
      MODE_COPY: begin
        pixel_next = in_data.src;
      end
      MODE_KEY: begin
        pixel_next = in_data.key_hit ? in_data.dst : in_data.src;
      end
      MODE_AVG: begin
        pixel_next = in_data.avg_ok ? in_data.avg : in_data.dst;
      end
      MODE_W80: begin
        pixel_next = in_data.q5;
      end
      MODE_DARKER: begin
        for (int i = 0; i < NumBytes; i++) begin
          if (!in_data.dark_key_hit && in_data.darker[i]) begin
            pixel_next[i] = in_data.q10[i];
          end
        end
      end
      default: begin
        pixel_next = in_data.dst;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_pixel <= pixel_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pixel_blend_modes_top.sv -----
// Channel      Handshake                Payload
// ------------ ------------------------ ------------------------------------
// pixel in     start, busy              src_byte0..2, dst_byte0..2
// pixel out    done (one-cycle strobe)  out_byte0..2
// config       cfg_valid, cfg_ready     cfg_index, cfg_data
//
// A pixel pair is taken on every clock edge with start high and busy low.
// Its result appears on out_byte0..2 with done high once it has passed
// the three register stages: the front stage, the reciprocal multiply
// and the mode select. One pixel per clock is sustained outside reset.
// Reset is synchronous; busy and not cfg_ready are high while rst is high.
// The receiver cannot stall, so results are never held back.
`default_nettype none

module pixel_blend_modes_top
  import pbm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire pbm_byte_t    src_byte0,
  input  wire pbm_byte_t    src_byte1,
  input  wire pbm_byte_t    src_byte2,
  input  wire pbm_byte_t    dst_byte0,
  input  wire pbm_byte_t    dst_byte1,
  input  wire pbm_byte_t    dst_byte2,
  output logic              done,
  output pbm_byte_t         out_byte0,
  output pbm_byte_t         out_byte1,
  output pbm_byte_t         out_byte2,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire pbm_reg_idx_t cfg_index,
  input  wire pbm_byte_t    cfg_data
);

  // Configuration registers. The user must change them only while the
  // pipeline is empty; the block does not enforce it. The front stage
  // reads them directly, later stages carry the mode along with each pixel.
  pbm_cfg_t cfg;

  logic                     in_transfer;
  logic                     s1_valid;
  pbm_s1_t                  s1_data;
  logic                     s2_valid;
  pbm_s2_t                  s2_data;
  pbm_byte_t [NumBytes-1:0] out_pixel;

  // The pipeline never stalls, so new pixels are refused only during reset.
  assign busy        = rst;
  assign cfg_ready   = !rst;
  assign in_transfer = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE: cfg.mode <= cfg_data[2:0];
        REG_KEY0: cfg.key0 <= cfg_data;
        REG_KEY1: cfg.key1 <= cfg_data;
        REG_KEY2: cfg.key2 <= cfg_data;
        default:  ;
      endcase
    end
  end

  // Stage one: per-byte sums, the average and the key comparisons.
  pbm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_transfer),
    .cfg       (cfg),
    .src       ({src_byte2, src_byte1, src_byte0}),
    .dst       ({dst_byte2, dst_byte1, dst_byte0}),
    .out_valid (s1_valid),
    .out_data  (s1_data)
  );

  // Stage two: divide the weighted sums by five and by ten.
  pbm_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_data  (s2_data)
  );

  // Stage three: pick the result for the current mode.
  pbm_select u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_data   (s2_data),
    .out_valid (done),
    .out_pixel (out_pixel)
  );

  assign out_byte0 = out_pixel[0];
  assign out_byte1 = out_pixel[1];
  assign out_byte2 = out_pixel[2];

  // Every accepted pixel yields a result after the front, scale and select registers.
  assert property (@(posedge clk) disable iff (rst) in_transfer |-> ##3 done)
    else $error("accepted pixel produced no result");

  // No result strobe appears without an accepted pixel that passed all three registers.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(in_transfer, 3))
    else $error("result strobe without an accepted pixel");

  // The middle stage holds a pixel only if one was accepted and passed front and scale.
  assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> $past(in_transfer, 2))
    else $error("stage two valid out of step with the input");

  // An unused mode passes the destination of the same pixel through.
  assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_data.mode != MODE_COPY && s2_data.mode != MODE_KEY
      && s2_data.mode != MODE_AVG && s2_data.mode != MODE_W80
      && s2_data.mode != MODE_DARKER
    |=> out_pixel == $past(s2_data.dst))
    else $error("unused mode changed the destination pixel");

endmodule

`default_nettype wire

// ----- dv/tb_pixel_blend_modes_top.sv -----
`default_nettype none

module tb_pixel_blend_modes_top;
  import pbm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned RESET_CYCLES  = 5;
  // The pipeline is three stages deep, so a few spare cycles cover any tail.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned NUM_PHASES    = 16;
  localparam int unsigned PHASE_ITEMS   = 112;

  // Register indexes past the last key register are decoded as no-ops.
  localparam pbm_reg_idx_t REG_SPARE_FIRST = REG_KEY2 + 4'd1;
  localparam pbm_reg_idx_t REG_SPARE_LAST  = '1;
  // Modes above the darker blend all keep the destination pixel.
  localparam pbm_mode_t MODE_KEEP_FIRST = MODE_DARKER + 3'd1;
  localparam pbm_mode_t MODE_KEEP_MID   = MODE_DARKER + 3'd2;
  localparam pbm_mode_t MODE_KEEP_LAST  = '1;

  // A pixel is indexed by byte position: element 0 is byte 0 (blue).
  typedef pbm_byte_t [NumBytes-1:0] pixel_t;

  typedef struct packed {
    pixel_t src;
    pixel_t dst;
  } pix_pair_t;

  // One row of the directed table: either a register write or a pixel
  // transfer, the latter optionally with its expected result typed in.
  typedef struct packed {
    logic         is_cfg;
    pbm_reg_idx_t idx;
    pbm_byte_t    data;
    pixel_t       src;
    pixel_t       dst;
    logic         typed;
    pixel_t       want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         start;
  logic         busy;
  pbm_byte_t    src_byte0, src_byte1, src_byte2;
  pbm_byte_t    dst_byte0, dst_byte1, dst_byte2;
  logic         done;
  pbm_byte_t    out_byte0, out_byte1, out_byte2;
  logic         cfg_valid;
  logic         cfg_ready;
  pbm_reg_idx_t cfg_index;
  pbm_byte_t    cfg_data;

  // Shadow copy of the configuration registers, updated on each accepted
  // register write.
  pbm_cfg_t     cfg_shadow;

  // Expected output pixels, oldest first, one per accepted pixel transfer.
  pixel_t       pending_pixels[$];
  // Expected result of the pixel currently presented on the input ports.
  pixel_t       next_want;
  pixel_t       got_pixel;
  pixel_t       oldest_want;

  int unsigned  cycle_count     = 0;
  int unsigned  mismatches      = 0;
  int unsigned  pixels_sent     = 0;
  int unsigned  results_checked = 0;
  int unsigned  reg_writes      = 0;
  logic [7:0]   modes_seen      = '0;

  pixel_blend_modes_top DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .src_byte0 (src_byte0),
    .src_byte1 (src_byte1),
    .src_byte2 (src_byte2),
    .dst_byte0 (dst_byte0),
    .dst_byte1 (dst_byte1),
    .dst_byte2 (dst_byte2),
    .done      (done),
    .out_byte0 (out_byte0),
    .out_byte1 (out_byte1),
    .out_byte2 (out_byte2),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // The watchdog ends a run that hangs on a handshake or loses results.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
             pending_pixels.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic pixel_t px(pbm_byte_t b0, pbm_byte_t b1, pbm_byte_t b2);
    pixel_t p;
    p[0] = b0;
    p[1] = b1;
    p[2] = b2;
    return p;
  endfunction

  // Computes the new destination pixel for the blend mode and color key
  // held in the given configuration.
  function automatic pixel_t blend_pixel(pbm_cfg_t c, pixel_t s, pixel_t d);
    pixel_t      r;
    logic        hit;
    int unsigned acc;
    r = d;
    case (c.mode)
      MODE_COPY: begin
        r = s;
      end
      MODE_KEY: begin
        // The green byte also matches on the alias value, whatever the key.
        hit = (s[0] == c.key0) && ((s[1] == c.key1) || (s[1] == KEY_GREEN_ALIAS)) &&
              (s[2] == c.key2);
        if (!hit) r = s;
      end
      MODE_AVG: begin
        // A saturated source byte anywhere in the pixel suppresses the average.
        if ((s[0] != BYTE_MAX) && (s[1] != BYTE_MAX) && (s[2] != BYTE_MAX)) begin
          for (int i = 0; i < NumBytes; i++) begin
            acc  = (int'(d[i]) + int'(s[i])) >> 1;
            r[i] = acc[7:0];
          end
        end
      end
      MODE_W80: begin
        for (int i = 0; i < NumBytes; i++) begin
          acc  = (int'(d[i]) * 20 + int'(s[i]) * 80) / 100;
          r[i] = acc[7:0];
        end
      end
      MODE_DARKER: begin
        // Here the key needs an exact match on all three bytes.
        hit = (s[0] == c.key0) && (s[1] == c.key1) && (s[2] == c.key2);
        if (!hit) begin
          for (int i = 0; i < NumBytes; i++) begin
            if (s[i] < d[i]) begin
              acc  = (int'(d[i]) * 3 + int'(s[i]) * 7) / 10;
              r[i] = acc[7:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Random byte that lands on the two extremes fairly often.
  function automatic pbm_byte_t rand_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return BYTE_MAX;
    return pbm_byte_t'($urandom);
  endfunction

  function automatic pbm_byte_t pick_key();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return BYTE_MAX;
    if (r == 2) return KEY_GREEN_ALIAS;
    return pbm_byte_t'($urandom);
  endfunction

  // Random pixel pair, steered toward exact key hits, alias hits, near
  // misses of the key and saturated source bytes so that every mode sees
  // its special cases.
  function automatic pix_pair_t gen_pair(pbm_cfg_t c);
    pix_pair_t   p;
    int unsigned r;
    int unsigned pos;
    for (int i = 0; i < NumBytes; i++) begin
      p.src[i] = rand_byte();
      p.dst[i] = rand_byte();
    end
    r   = $urandom_range(0, 99);
    pos = $urandom_range(0, NumBytes - 1);
    if (r < 20) begin
      p.src = px(c.key0, c.key1, c.key2);
    end else if (r < 30) begin
      p.src = px(c.key0, KEY_GREEN_ALIAS, c.key2);
    end else if (r < 38) begin
      p.src      = px(c.key0, c.key1, c.key2);
      p.src[pos] = p.src[pos] ^ pbm_byte_t'(1 << $urandom_range(0, 7));
    end else if (r < 50) begin
      p.src[pos] = BYTE_MAX;
    end
    return p;
  endfunction

  // Gap before the next pixel. Style zero runs back to back; otherwise
  // most gaps are short and a few are long.
  function automatic int unsigned pick_gap(int unsigned style);
    int unsigned r;
    if (style == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH at cycle %0d, %s: got %02h, want %02h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Result monitor. A done strobe is matched against the oldest pending
  // pixel before this edge's input transfer is queued, so the order of the
  // two inside one edge never matters.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        got_pixel = px(out_byte0, out_byte1, out_byte2);
        if (pending_pixels.size() == 0) begin
          report_mismatch("result with no pixel pending", 32'(got_pixel), 0);
        end else begin
          oldest_want = pending_pixels.pop_front();
          for (int i = 0; i < NumBytes; i++) begin
            if (got_pixel[i] !== oldest_want[i]) begin
              report_mismatch($sformatf("out_byte%0d of result %0d", i, results_checked),
                              32'(got_pixel[i]), 32'(oldest_want[i]));
            end
          end
          results_checked++;
        end
      end
      if (start && !busy) pending_pixels.push_back(next_want);
    end
  end

  // Presents one pixel pair after the requested gap and holds it until the
  // block takes the transfer. Start is written once per falling edge, so a
  // back-to-back transfer simply leaves it high.
  task automatic send_pixel(pixel_t s, pixel_t d, logic typed, pixel_t want,
                            int unsigned gap);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     = 1'b1;
    src_byte0 = s[0];
    src_byte1 = s[1];
    src_byte2 = s[2];
    dst_byte0 = d[0];
    dst_byte1 = d[1];
    dst_byte2 = d[2];
    next_want = typed ? want : blend_pixel(cfg_shadow, s, d);
    do @(posedge clk); while (busy);
    modes_seen[cfg_shadow.mode] = 1'b1;
    pixels_sent++;
  endtask

  // Drops start and waits until every pending result has come back, plus
  // a few cycles of margin, so that a register write finds the block idle.
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(pbm_reg_idx_t idx, pbm_byte_t data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE: cfg_shadow.mode = data[2:0];
      REG_KEY0: cfg_shadow.key0 = data;
      REG_KEY1: cfg_shadow.key1 = data;
      REG_KEY2: cfg_shadow.key2 = data;
      default: begin
      end
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin : main
    stim_row_t   rows[$];
    stim_row_t   row;
    pix_pair_t   pair;
    pbm_mode_t   mode;
    int unsigned style;
    pixel_t      no_want;

    // Every input starts at a known value; reset is held for a few cycles.
    rst        = 1'b1;
    start      = 1'b0;
    src_byte0  = '0;
    src_byte1  = '0;
    src_byte2  = '0;
    dst_byte0  = '0;
    dst_byte1  = '0;
    dst_byte2  = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_MODE;
    cfg_data   = '0;
    next_want  = '0;
    no_want    = '0;
    cfg_shadow = '0;

    // Directed table. Rows with a typed result are the ones whose answer is
    // plain: copy, key hits and a key miss on byte 0, a saturated source in
    // average mode, the all-zero and all-ones weighted blend, darker with a
    // key hit or with no darker byte, and the modes that keep the destination.
    row = '0;
    // Copy mode straight out of reset, at both extremes.
    row.src = px(8'h00, 8'h00, 8'h00); row.dst = px(8'hFF, 8'hFF, 8'hFF);
    row.typed = 1'b1; row.want = row.src; rows.push_back(row);
    row.src = px(8'hFF, 8'hFF, 8'hFF); row.dst = px(8'h00, 8'h00, 8'h00);
    row.want = row.src; rows.push_back(row);
    row.src = px(8'h12, 8'h34, 8'h56); row.dst = px(8'hAB, 8'hCD, 8'hEF);
    row.want = row.src; rows.push_back(row);
    // Color key with the reset key of zero: a black source is transparent,
    // and so is one whose green byte carries the alias value.
    row = '0; row.is_cfg = 1'b1; row.idx = REG_MODE; row.data = 8'(MODE_KEY);
    rows.push_back(row);
    row = '0; row.src = px(8'h00, 8'h00, 8'h00); row.dst = px(8'h11, 8'h22, 8'h33);
    row.typed = 1'b1; row.want = row.dst; rows.push_back(row);
    row.src = px(8'h00, KEY_GREEN_ALIAS, 8'h00); row.dst = px(8'h44, 8'h55, 8'h66);
    row.want = row.dst; rows.push_back(row);
    // A nonzero key: exact hit, alias hit, and misses on byte 0 and byte 2.
    row = '0; row.is_cfg = 1'b1; row.idx = REG_KEY0; row.data = 8'h10; rows.push_back(row);
    row.idx = REG_KEY1; row.data = 8'h80; rows.push_back(row);
    row.idx = REG_KEY2; row.data = 8'hF0; rows.push_back(row);
    row = '0; row.src = px(8'h10, 8'h80, 8'hF0); row.dst = px(8'h01, 8'h02, 8'h03);
    row.typed = 1'b1; row.want = row.dst; rows.push_back(row);
    row.src = px(8'h10, KEY_GREEN_ALIAS, 8'hF0); row.dst = px(8'h04, 8'h05, 8'h06);
    row.want = row.dst; rows.push_back(row);
    row.src = px(8'h11, 8'h80, 8'hF0); row.dst = px(8'h07, 8'h08, 8'h09);
    row.want = row.src; rows.push_back(row);
    row = '0; row.src = px(8'h10, 8'h80, 8'hF1); row.dst = px(8'h0A, 8'h0B, 8'h0C);
    rows.push_back(row);
    // Average, then a saturated source byte in two positions.
    row = '0; row.is_cfg = 1'b1; row.idx = REG_MODE; row.data = 8'(MODE_AVG);
    rows.push_back(row);
    row = '0; row.src = px(8'hFE, 8'h00, 8'h10); row.dst = px(8'h02, 8'hFF, 8'h11);
    rows.push_back(row);
    row.src = px(8'hFF, 8'h10, 8'h10); row.dst = px(8'h01, 8'h02, 8'h03);
    row.typed = 1'b1; row.want = row.dst; rows.push_back(row);
    row.src = px(8'h10, 8'h10, 8'hFF); row.dst = px(8'hC1, 8'hC2, 8'hC3);
    row.want = row.dst; rows.push_back(row);
    // Weighted 80/20 at both extremes and with mixed bytes.
    row = '0; row.is_cfg = 1'b1; row.idx = REG_MODE; row.data = 8'(MODE_W80);
    rows.push_back(row);
    row = '0; row.src = px(8'hFF, 8'hFF, 8'hFF); row.dst = px(8'hFF, 8'hFF, 8'hFF);
    row.typed = 1'b1; row.want = px(8'hFF, 8'hFF, 8'hFF); rows.push_back(row);
    row.src = px(8'h00, 8'h00, 8'h00); row.dst = px(8'h00, 8'h00, 8'h00);
    row.want = px(8'h00, 8'h00, 8'h00); rows.push_back(row);
    row = '0; row.src = px(8'hFF, 8'h00, 8'h80); row.dst = px(8'h00, 8'hFF, 8'h40);
    rows.push_back(row);
    // Darker 70/30: exact key hit, alias value with no special meaning,
    // every byte darker, no byte darker, and a mix.
    row = '0; row.is_cfg = 1'b1; row.idx = REG_MODE; row.data = 8'(MODE_DARKER);
    rows.push_back(row);
    row = '0; row.src = px(8'h10, 8'h80, 8'hF0); row.dst = px(8'hFF, 8'hFF, 8'hFF);
    row.typed = 1'b1; row.want = row.dst; rows.push_back(row);
    row = '0; row.src = px(8'h10, KEY_GREEN_ALIAS, 8'hF0); row.dst = px(8'hFF, 8'hFF, 8'hFF);
    rows.push_back(row);
    row.src = px(8'h00, 8'h00, 8'h00); row.dst = px(8'hFF, 8'hFF, 8'hFF); rows.push_back(row);
    row.src = px(8'hFF, 8'hFF, 8'hFF); row.dst = px(8'h00, 8'h00, 8'h00);
    row.typed = 1'b1; row.want = row.dst; rows.push_back(row);
    row = '0; row.src = px(8'h20, 8'h90, 8'h10); row.dst = px(8'h40, 8'h50, 8'hF0);
    rows.push_back(row);
    // The spare modes keep the destination, including a mode write whose
    // upper data bits are set and must be dropped.
    row = '0; row.is_cfg = 1'b1; row.idx = REG_MODE; row.data = 8'(MODE_KEEP_FIRST);
    rows.push_back(row);
    row = '0; row.src = px(8'h9A, 8'hBC, 8'hDE); row.dst = px(8'h12, 8'h34, 8'h56);
    row.typed = 1'b1; row.want = row.dst; rows.push_back(row);
    row = '0; row.is_cfg = 1'b1; row.idx = REG_MODE; row.data = {5'b11111, MODE_KEEP_MID};
    rows.push_back(row);
    row = '0; row.src = px(8'h00, 8'hFF, 8'h00); row.dst = px(8'h78, 8'h9A, 8'hBC);
    row.typed = 1'b1; row.want = row.dst; rows.push_back(row);
    row = '0; row.is_cfg = 1'b1; row.idx = REG_MODE; row.data = 8'(MODE_KEEP_LAST);
    rows.push_back(row);
    row = '0; row.src = px(8'h55, 8'hAA, 8'h55); row.dst = px(8'hAA, 8'h55, 8'hAA);
    row.typed = 1'b1; row.want = row.dst; rows.push_back(row);
    // Writes to unused indexes must not disturb the mode; copy comes back
    // with upper data bits set.
    row = '0; row.is_cfg = 1'b1; row.idx = REG_SPARE_FIRST; row.data = 8'hFF;
    rows.push_back(row);
    row.idx = REG_SPARE_LAST; row.data = 8'hFF; rows.push_back(row);
    row = '0; row.src = px(8'h01, 8'h02, 8'h03); row.dst = px(8'hF1, 8'hF2, 8'hF3);
    row.typed = 1'b1; row.want = row.dst; rows.push_back(row);
    row = '0; row.is_cfg = 1'b1; row.idx = REG_MODE; row.data = {5'b10101, MODE_COPY};
    rows.push_back(row);
    row = '0; row.src = px(8'hC3, 8'h3C, 8'h81); row.dst = px(8'h00, 8'h00, 8'h00);
    row.typed = 1'b1; row.want = row.src; rows.push_back(row);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[k]) begin
      if (rows[k].is_cfg) begin
        wait_idle();
        write_reg(rows[k].idx, rows[k].data);
      end else begin
        send_pixel(rows[k].src, rows[k].dst, rows[k].typed, rows[k].want,
                   $urandom_range(0, 2));
      end
    end

    // Random phases. The first eight walk every mode in turn, the rest pick
    // modes at random; every register is rewritten at the start of each
    // phase, with keys drawn often from the extremes and the alias value.
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      mode = (phase < 8) ? pbm_mode_t'(phase) : pbm_mode_t'($urandom_range(0, 7));
      write_reg(REG_MODE, {5'($urandom_range(0, 31)), mode});
      write_reg(REG_KEY0, pick_key());
      write_reg(REG_KEY1, pick_key());
      write_reg(REG_KEY2, pick_key());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(pbm_reg_idx_t'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  pbm_byte_t'($urandom));
      end
      style = $urandom_range(0, 2);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        pair = gen_pair(cfg_shadow);
        send_pixel(pair.src, pair.dst, 1'b0, no_want, pick_gap(style));
      end
    end

    wait_idle();

    $display("Sent %0d pixel transfers and checked %0d results across %0d register writes",
             pixels_sent, results_checked, reg_writes);
    $display("Blend modes exercised (bit per mode): %08b", modes_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- pixel_blend_modes_top.f -----
sv/pbm_pkg.sv
sv/pbm_front.sv
sv/pbm_scale.sv
sv/pbm_select.sv
sv/pixel_blend_modes_top.sv
dv/tb_pixel_blend_modes_top.sv
